// ===== design/ntp_pkg.sv =====
`timescale 1ns / 1ps
// ntp_pkg: shared types, constants and small tables for the thermal plant step
// used by ntp_ctrl, ntp_dp and nonlinear_thermal_plant_step; depends on nothing

package ntp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_WIDTH = 32;
  localparam int Q_BITS = 30;
  localparam int Y_SHIFT = Q_BITS - FRAC_BITS;
  localparam int SINE_SHIFT = 2 * Q_BITS - FRAC_BITS;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W = 4;

  // 2*pi in Q16.16, rounded
  localparam logic [32:0] TWO_PI = 33'd411775;
  // multiple of 2*pi above 2^31, makes the reduction argument non-negative
  localparam logic [32:0] RED_OFFSET = 33'd2147818400;
  localparam logic [32:0] PI_Q30 = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  localparam logic [CNT_W-1:0] RED_TOP = 4'd13;
  localparam logic [CNT_W-1:0] HORNER_LAST = 4'd3;

  localparam logic [CNT_W-1:0] TERM_A = 4'd0;
  localparam logic [CNT_W-1:0] TERM_SQ = 4'd1;
  localparam logic [CNT_W-1:0] TERM_B = 4'd2;
  localparam logic [CNT_W-1:0] TERM_C = 4'd3;
  localparam logic [CNT_W-1:0] TERM_D = 4'd4;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TEMP = 3'd5;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] heat_input;
    logic signed [31:0] initial_temp;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_RED,
    OP_FOLD1,
    OP_FOLD2,
    OP_SQ,
    OP_X2,
    OP_HMUL,
    OP_HDV,
    OP_HREC,
    OP_HEST,
    OP_HFIX,
    OP_SMUL,
    OP_SGET,
    OP_TMUL,
    OP_TSC,
    OP_TACC,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] idx;
    logic             restart;
  } cmd_t;

  // horner divisors 72, 42, 20, 6 split into a shift and an odd factor
  function automatic logic [1:0] div_shift(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0: r = 2'd3;
      2'd1: r = 2'd1;
      2'd2: r = 2'd2;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] div_odd(input logic [1:0] i);
    logic [4:0] r;
    case (i)
      2'd0: r = 5'd9;
      2'd1: r = 5'd21;
      2'd2: r = 5'd5;
      default: r = 5'd3;
    endcase
    return r;
  endfunction

  // floor(2^33 / odd factor)
  function automatic logic [31:0] div_magic(input logic [1:0] i);
    logic [31:0] r;
    case (i)
      2'd0: r = 32'd954437176;
      2'd1: r = 32'd409044504;
      2'd2: r = 32'd1717986918;
      default: r = 32'd2863311530;
    endcase
    return r;
  endfunction

endpackage

// ===== design/ntp_ctrl.sv =====
`timescale 1ns / 1ps
// ntp_ctrl: sequencer for one plant step, issues one datapath command per cycle
// depends on ntp_pkg (cmd_t, op codes, counts)

module ntp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           restart,
  output logic           out_valid,
  input  logic           out_ready,
  output ntp_pkg::cmd_t  cmd
);

  typedef enum logic [16:0] {
    ST_IDLE  = 17'b00000000000000001,
    ST_RED   = 17'b00000000000000010,
    ST_FOLD1 = 17'b00000000000000100,
    ST_FOLD2 = 17'b00000000000001000,
    ST_SQ    = 17'b00000000000010000,
    ST_X2    = 17'b00000000000100000,
    ST_HMUL  = 17'b00000000001000000,
    ST_HDV   = 17'b00000000010000000,
    ST_HREC  = 17'b00000000100000000,
    ST_HEST  = 17'b00000001000000000,
    ST_HFIX  = 17'b00000010000000000,
    ST_SMUL  = 17'b00000100000000000,
    ST_SGET  = 17'b00001000000000000,
    ST_TMUL  = 17'b00010000000000000,
    ST_TSC   = 17'b00100000000000000,
    ST_TACC  = 17'b01000000000000000,
    ST_DONE  = 17'b10000000000000000
  } state_t;

  state_t                    state, state_next;
  logic [ntp_pkg::CNT_W-1:0] cnt, cnt_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd.op = ntp_pkg::OP_NOP;
    cmd.idx = cnt;
    cmd.restart = restart;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = ntp_pkg::OP_LOAD;
          state_next = ST_RED;
          cnt_next = ntp_pkg::RED_TOP;
        end
      end
      ST_RED: begin
        cmd.op = ntp_pkg::OP_RED;
        if (cnt == '0) begin
          state_next = ST_FOLD1;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_FOLD1: begin
        cmd.op = ntp_pkg::OP_FOLD1;
        state_next = ST_FOLD2;
      end
      ST_FOLD2: begin
        cmd.op = ntp_pkg::OP_FOLD2;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.op = ntp_pkg::OP_SQ;
        state_next = ST_X2;
      end
      ST_X2: begin
        cmd.op = ntp_pkg::OP_X2;
        state_next = ST_HDV;
        cnt_next = '0;
      end
      ST_HMUL: begin
        cmd.op = ntp_pkg::OP_HMUL;
        state_next = ST_HDV;
      end
      ST_HDV: begin
        cmd.op = ntp_pkg::OP_HDV;
        state_next = ST_HREC;
      end
      ST_HREC: begin
        cmd.op = ntp_pkg::OP_HREC;
        state_next = ST_HEST;
      end
      ST_HEST: begin
        cmd.op = ntp_pkg::OP_HEST;
        state_next = ST_HFIX;
      end
      ST_HFIX: begin
        cmd.op = ntp_pkg::OP_HFIX;
        if (cnt == ntp_pkg::HORNER_LAST) begin
          state_next = ST_SMUL;
        end else begin
          state_next = ST_HMUL;
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SMUL: begin
        cmd.op = ntp_pkg::OP_SMUL;
        state_next = ST_SGET;
      end
      ST_SGET: begin
        cmd.op = ntp_pkg::OP_SGET;
        state_next = ST_TMUL;
        cnt_next = ntp_pkg::TERM_A;
      end
      ST_TMUL: begin
        cmd.op = ntp_pkg::OP_TMUL;
        state_next = ST_TSC;
      end
      ST_TSC: begin
        cmd.op = ntp_pkg::OP_TSC;
        // the square only feeds the next product, it is not summed
        if (cnt == ntp_pkg::TERM_SQ) begin
          state_next = ST_TMUL;
          cnt_next = cnt + 1'b1;
        end else begin
          state_next = ST_TACC;
        end
      end
      ST_TACC: begin
        cmd.op = ntp_pkg::OP_TACC;
        if (cnt == ntp_pkg::TERM_D) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_TMUL;
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op = ntp_pkg::OP_DONE;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.op == ntp_pkg::OP_DONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after a word was taken");
  a_done_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == ntp_pkg::OP_DONE |-> !out_valid || out_ready)
    else $error("result written over an untaken word");
  a_red_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RED |-> cnt <= ntp_pkg::RED_TOP)
    else $error("reduction step out of range");
  a_term_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TMUL || state == ST_TSC || state == ST_TACC) |-> cnt <= ntp_pkg::TERM_D)
    else $error("term index out of range");

endmodule

// ===== design/ntp_dp.sv =====
`timescale 1ns / 1ps
// ntp_dp: plant state, shared 32x32 multiplier, sine argument reduction,
// horner evaluation and saturating accumulation; depends on ntp_pkg

module ntp_dp (
  input  logic                clk,
  input  logic                rst,
  input  ntp_pkg::cmd_t       cmd,
  input  ntp_pkg::cfg_t       cfg,
  output logic signed [31:0]  temperature,
  output logic                saturated
);

  logic signed [31:0] older_temp, last_temp, prev_heat;
  logic [32:0]        red, y;
  logic               sneg;
  logic [31:0]        x2, dv;
  logic [30:0]        t, q;
  logic [ntp_pkg::FRAC_BITS:0] s;
  logic [63:0]        prod;
  logic               pneg;
  logic signed [31:0] term;
  logic signed [33:0] acc;
  logic               sat;

  // multiplier operands
  logic [31:0]        ma, mb;
  logic               mul_en;
  logic signed [31:0] tp, tq;
  logic [31:0]        pmag, qmag;
  logic               qneg;

  logic [32:0]        red_lim, y0, y1;
  logic [31:0]        hbase, hprod, hrem;
  logic [1:0]         hi;
  logic [30:0]        hq;
  logic [47:0]        m, lim, mc;
  logic               msat;
  logic [31:0]        term_val;
  logic signed [33:0] acc_max, acc_min;
  logic signed [31:0] sum_clip;
  logic               sum_sat;

  always_comb begin
    tp = cfg.coef_a;
    tq = last_temp;
    case (cmd.idx)
      ntp_pkg::TERM_A: begin
        tp = cfg.coef_a;
        tq = last_temp;
      end
      ntp_pkg::TERM_SQ: begin
        tp = older_temp;
        tq = older_temp;
      end
      ntp_pkg::TERM_B: begin
        tp = cfg.coef_b;
        tq = term;
      end
      ntp_pkg::TERM_C: begin
        tp = cfg.coef_c;
        tq = cfg.heat_input;
      end
      ntp_pkg::TERM_D: begin
        tp = cfg.coef_d;
        tq = '0;
      end
      default: begin
        tp = '0;
        tq = '0;
      end
    endcase
    pmag = tp[31] ? (~tp + 32'sd1) : tp;
    if (cmd.idx == ntp_pkg::TERM_D) begin
      qmag = 32'(s);
      qneg = sneg;
    end else begin
      qmag = tq[31] ? (~tq + 32'sd1) : tq;
      qneg = tq[31];
    end
  end

  always_comb begin
    mul_en = 1'b1;
    ma = '0;
    mb = '0;
    case (cmd.op)
      ntp_pkg::OP_SQ: begin
        ma = y[31:0];
        mb = y[31:0];
      end
      ntp_pkg::OP_HMUL: begin
        ma = x2;
        mb = 32'(t);
      end
      ntp_pkg::OP_HREC: begin
        ma = dv;
        mb = ntp_pkg::div_magic(cmd.idx[1:0]);
      end
      ntp_pkg::OP_SMUL: begin
        ma = y[31:0];
        mb = 32'(t);
      end
      ntp_pkg::OP_TMUL: begin
        ma = pmag;
        mb = qmag;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    // reduction: one conditional subtract of 2*pi << k per cycle
    red_lim = ntp_pkg::TWO_PI << cmd.idx;
    y0 = red << ntp_pkg::Y_SHIFT;
    y1 = (y > ntp_pkg::PI_Q30) ? ntp_pkg::PI_Q30 : y;

    // horner divide: estimate from reciprocal is low by at most one
    hi = cmd.idx[1:0];
    hbase = (hi == 2'd0) ? x2 : prod[ntp_pkg::Q_BITS+31:ntp_pkg::Q_BITS];
    hprod = 32'(q) * 32'(ntp_pkg::div_odd(hi));
    hrem = dv - hprod;
    hq = q + 31'(hrem >= 32'(ntp_pkg::div_odd(hi)));

    // product scaling, magnitude truncated and clipped
    m = prod[63:ntp_pkg::FRAC_BITS];
    lim = pneg ? (48'd1 << (ntp_pkg::WORD_WIDTH - 1))
               : ((48'd1 << (ntp_pkg::WORD_WIDTH - 1)) - 48'd1);
    msat = (m > lim);
    mc = msat ? lim : m;
    term_val = pneg ? (~mc[31:0] + 32'd1) : mc[31:0];

    acc_max = 34'sd2147483647;
    acc_min = -34'sd2147483648;
    sum_sat = (acc > acc_max) || (acc < acc_min);
    if (acc > acc_max) begin
      sum_clip = 32'sh7fffffff;
    end else if (acc < acc_min) begin
      sum_clip = 32'sh80000000;
    end else begin
      sum_clip = acc[31:0];
    end
  end

  // plant state
  always_ff @(posedge clk) begin
    if (rst) begin
      older_temp <= '0;
      last_temp <= '0;
      prev_heat <= '0;
    end else begin
      case (cmd.op)
        ntp_pkg::OP_LOAD: begin
          if (cmd.restart) begin
            last_temp <= cfg.initial_temp;
            older_temp <= '0;
          end
        end
        ntp_pkg::OP_DONE: begin
          older_temp <= last_temp;
          last_temp <= sum_clip;
          prev_heat <= cfg.heat_input;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= 64'(ma) * 64'(mb);
    end
    case (cmd.op)
      ntp_pkg::OP_LOAD: begin
        red <= cmd.restart ? ntp_pkg::RED_OFFSET
                           : (33'({prev_heat[31], prev_heat}) + ntp_pkg::RED_OFFSET);
        acc <= '0;
        sat <= 1'b0;
      end
      ntp_pkg::OP_RED: begin
        if (red >= red_lim) begin
          red <= red - red_lim;
        end
      end
      ntp_pkg::OP_FOLD1: begin
        if (y0 >= ntp_pkg::PI_Q30) begin
          y <= y0 - ntp_pkg::PI_Q30;
          sneg <= 1'b1;
        end else begin
          y <= y0;
          sneg <= 1'b0;
        end
      end
      ntp_pkg::OP_FOLD2: begin
        y <= (y1 > ntp_pkg::HALF_PI_Q30) ? (ntp_pkg::PI_Q30 - y1) : y1;
      end
      ntp_pkg::OP_X2: begin
        x2 <= prod[ntp_pkg::Q_BITS+31:ntp_pkg::Q_BITS];
      end
      ntp_pkg::OP_HDV: begin
        dv <= hbase >> ntp_pkg::div_shift(hi);
      end
      ntp_pkg::OP_HEST: begin
        q <= prod[63:33];
      end
      ntp_pkg::OP_HFIX: begin
        t <= ntp_pkg::Q30_ONE - hq;
      end
      ntp_pkg::OP_SGET: begin
        s <= prod[ntp_pkg::SINE_SHIFT+ntp_pkg::FRAC_BITS:ntp_pkg::SINE_SHIFT];
      end
      ntp_pkg::OP_TMUL: begin
        pneg <= tp[31] ^ qneg;
      end
      ntp_pkg::OP_TSC: begin
        term <= term_val;
        sat <= sat | msat;
      end
      ntp_pkg::OP_TACC: begin
        if (cmd.idx == ntp_pkg::TERM_B) begin
          acc <= acc - 34'(term);
        end else begin
          acc <= acc + 34'(term);
        end
      end
      ntp_pkg::OP_DONE: begin
        temperature <= sum_clip;
        saturated <= sat | sum_sat;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/nonlinear_thermal_plant_step.sv =====
`timescale 1ns / 1ps
// nonlinear_thermal_plant_step: top level, configuration registers and the
// sequencer/datapath pair; depends on ntp_pkg, ntp_ctrl, ntp_dp
//
//   channel  handshake              payload
//   in       in_valid / in_ready    restart
//   out      out_valid / out_ready  temperature, saturated
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// the result word is loaded once the sequencer has run through all its steps, and
// a new word is taken only after that, since in_ready waits for the idle state;
// the pace is set by the 14-step sine argument reduction and the single shared
// 32x32 multiplier that serves the sine polynomial and all five products in turn
// in_ready is high only while the sequencer is idle; a finished word waits in
// the output register and the next step may start meanwhile
// a stalled output holds the sequencer at its last step; cfg_ready is always high
// synchronous reset clears plant state, coefficients and the output valid

module nonlinear_thermal_plant_step (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 temperature,
  output logic                               saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ntp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);

  ntp_pkg::cfg_t cfg;
  ntp_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  // indices beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ntp_pkg::REG_COEF_A: cfg.coef_a <= cfg_data;
        ntp_pkg::REG_COEF_B: cfg.coef_b <= cfg_data;
        ntp_pkg::REG_COEF_C: cfg.coef_c <= cfg_data;
        ntp_pkg::REG_COEF_D: cfg.coef_d <= cfg_data;
        ntp_pkg::REG_HEAT: cfg.heat_input <= cfg_data;
        ntp_pkg::REG_INIT_TEMP: cfg.initial_temp <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ntp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ntp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .temperature (temperature),
    .saturated   (saturated)
  );

endmodule
